/* src/wpjs_pkg.sv */
// ----------------------------------------------------------------------------
// wpjs_pkg
// Shared types and constants for the weighted priority job scheduler.
// ----------------------------------------------------------------------------
package wpjs_pkg;

    // item kinds carried in the slave-side tuser
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam int KIND_BITS     = 2;
    localparam int FIELD_BITS    = 16;
    localparam int SUM_BITS      = 38;
    localparam int OCC_BITS      = 7;
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 64;
    localparam int OUT_USER_BITS = 2;

    // day tag of a stored job; only compared for equality
    localparam int DAY_BITS = 32;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // insert the key at its sorted place
        logic srv;   // head lost one unit, re-place it using the key
        logic rmv;   // head finished, everything moves up one place
    } t_chain_cmd;

endpackage

/* src/weighted_priority_job_scheduler_core.sv */
// ----------------------------------------------------------------------------
// weighted_priority_job_scheduler_core
// Bounded job store kept as a sorted cell chain; serves the heaviest job per tick.
// ----------------------------------------------------------------------------
// Result: the item and weight*units product are registered at the input beat;
//   the chain/sum update and the rise of o_m_tvalid follow once the previous
//   result beat no longer waits on i_m_tready.
// Flow: tready is low from the beat until the update, so no new item is taken before then.
// Reset: clears job count, penalty sum, day counter and both handshakes; the
//   cells are not cleared, slots at or beyond the count are never read.
module weighted_priority_job_scheduler_core #(
    parameter int CAPACITY    = 64,
    parameter int WEIGHT_BITS = 16,
    parameter int UNIT_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // kind
    input  logic [wpjs_pkg::KIND_BITS-1:0]      i_s_tuser,
    // job_weight[15:0], job_units[31:16]
    input  logic [wpjs_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // served[0], status[1]
    output logic [wpjs_pkg::OUT_USER_BITS-1:0]  o_m_tuser,
    // served_weight[15:0], pending_penalty[53:16], occupancy[60:54], zero[63:61]
    output logic [wpjs_pkg::OUT_DATA_BITS-1:0]  o_m_tdata
);

    localparam int WB = WEIGHT_BITS;
    localparam int UB = UNIT_BITS;
    localparam int PW = WB + UB;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SB = wpjs_pkg::SUM_BITS;
    localparam int DB = wpjs_pkg::DAY_BITS;
    localparam int FB = wpjs_pkg::FIELD_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic {ST_IDLE, ST_EXEC} t_state;

    t_state                          r_state, n_state;
    logic [wpjs_pkg::KIND_BITS-1:0]  r_kind, n_kind;
    logic [WB-1:0]                   r_w, n_w;
    logic [UB-1:0]                   r_u, n_u;
    logic [PW-1:0]                   r_prod, n_prod;
    logic [CW-1:0]                   r_count, n_count;
    logic [SB-1:0]                   r_sum, n_sum;
    logic [DB-1:0]                   r_day, n_day;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_served, n_out_served;
    logic [FB-1:0]                   r_out_sw, n_out_sw;
    logic [SB-1:0]                   r_out_sum, n_out_sum;
    logic [wpjs_pkg::OCC_BITS-1:0]   r_out_occ, n_out_occ;
    logic                            r_out_status, n_out_status;

    logic                            w_in_fire;
    logic                            w_commit;
    logic [WB-1:0]                   w_in_w;
    logic [UB-1:0]                   w_in_u;
    wpjs_pkg::t_chain_cmd            w_cmd;
    logic [WB-1:0]                   w_key_w;
    logic [UB-1:0]                   w_key_u;
    logic [DB-1:0]                   w_key_d;
    logic [WB-1:0]                   w_head_w;
    logic [UB-1:0]                   w_head_u;
    logic [DB-1:0]                   w_head_d;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_fire  = i_s_tvalid && o_s_tready;
    assign w_commit   = (r_state == ST_EXEC) && (!r_out_valid || i_m_tready);
    assign w_in_w     = WB'(i_s_tdata[FB-1:0]);
    assign w_in_u     = UB'(i_s_tdata[2*FB-1:FB]);

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_w          = r_w;
        n_u          = r_u;
        n_prod       = r_prod;
        n_count      = r_count;
        n_sum        = r_sum;
        n_day        = r_day;
        n_out_valid  = r_out_valid;
        n_out_served = r_out_served;
        n_out_sw     = r_out_sw;
        n_out_sum    = r_out_sum;
        n_out_occ    = r_out_occ;
        n_out_status = r_out_status;
        w_cmd        = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_in_fire) begin
            n_kind  = i_s_tuser;
            n_w     = w_in_w;
            n_u     = w_in_u;
            n_prod  = PW'(w_in_w) * PW'(w_in_u);
            n_state = ST_EXEC;
        end

        if (w_commit) begin
            n_state      = ST_IDLE;
            n_out_valid  = 1'b1;
            n_out_served = 1'b0;
            n_out_sw     = '0;
            n_out_status = 1'b0;
            case (r_kind)
                wpjs_pkg::KIND_ADD: begin
                    if (r_u != '0) begin
                        if (r_count >= CAP_C) begin
                            n_out_status = 1'b1;
                        end else begin
                            w_cmd.ins = 1'b1;
                            n_count   = r_count + CW'(1);
                            n_sum     = r_sum + SB'(r_prod);
                        end
                    end
                    n_out_sum = n_sum;
                    n_out_occ = wpjs_pkg::OCC_BITS'(n_count);
                end
                wpjs_pkg::KIND_TICK: begin
                    if (r_count != '0) begin
                        n_out_served = 1'b1;
                        n_out_sw     = FB'(w_head_w);
                        n_sum        = r_sum - SB'(w_head_w);
                        if (w_head_u == UB'(1)) begin
                            w_cmd.rmv = 1'b1;
                            n_count   = r_count - CW'(1);
                        end else begin
                            w_cmd.srv = 1'b1;
                        end
                    end
                    n_day     = r_day + DB'(1);
                    n_out_sum = n_sum;
                    n_out_occ = wpjs_pkg::OCC_BITS'(n_count);
                end
                wpjs_pkg::KIND_REPORT: begin
                    n_out_sum = r_sum;
                    n_out_occ = wpjs_pkg::OCC_BITS'(r_count);
                    n_count   = '0;
                    n_sum     = '0;
                    n_day     = '0;
                end
                default: begin
                    n_out_sum = r_sum;
                    n_out_occ = wpjs_pkg::OCC_BITS'(r_count);
                end
            endcase
        end

        // insert uses the new job; a served head is re-placed with one unit less
        if (w_cmd.ins) begin
            w_key_w = r_w;
            w_key_u = r_u;
            w_key_d = r_day;
        end else begin
            w_key_w = w_head_w;
            w_key_u = w_head_u - UB'(1);
            w_key_d = w_head_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_day       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_day       <= n_day;
            r_out_valid <= n_out_valid;
        end
        r_kind       <= n_kind;
        r_w          <= n_w;
        r_u          <= n_u;
        r_prod       <= n_prod;
        r_out_served <= n_out_served;
        r_out_sw     <= n_out_sw;
        r_out_sum    <= n_out_sum;
        r_out_occ    <= n_out_occ;
        r_out_status <= n_out_status;
    end

    wpjs_chain #(
        .CAPACITY (CAPACITY),
        .WB       (WB),
        .UB       (UB),
        .CW       (CW)
    ) u_chain (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_count  (r_count),
        .i_key_w  (w_key_w),
        .i_key_u  (w_key_u),
        .i_key_d  (w_key_d),
        .o_head_w (w_head_w),
        .o_head_u (w_head_u),
        .o_head_d (w_head_d)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = {r_out_status, r_out_served};
    assign o_m_tdata  = {3'b000, r_out_occ, r_out_sum, r_out_sw};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("job count above capacity");

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_sum == '0))
        else $error("penalty sum nonzero with empty store");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (r_count == CAP_C))
        else $error("drop reported while store not full");

    a_serve_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> !o_m_tuser[1])
        else $error("served and dropped on one beat");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (o_m_tvalid && o_s_tready))
        else $error("committed item gave no result beat");

endmodule

/* src/wpjs_cell.sv */
// ----------------------------------------------------------------------------
// wpjs_cell
// One slot of the sorted job chain: holds a job and trades with its neighbors.
// ----------------------------------------------------------------------------
module wpjs_cell #(
    parameter int IDX = 0,
    parameter int WB  = 16,
    parameter int UB  = 16,
    parameter int CW  = 7
) (
    input  logic                          i_clk,
    input  wpjs_pkg::t_chain_cmd          i_cmd,
    input  logic [CW-1:0]                 i_count,
    input  logic [WB-1:0]                 i_key_w,
    input  logic [UB-1:0]                 i_key_u,
    input  logic [wpjs_pkg::DAY_BITS-1:0] i_key_d,
    input  logic                          i_prev_beats,
    input  logic [WB-1:0]                 i_prev_w,
    input  logic [UB-1:0]                 i_prev_u,
    input  logic [wpjs_pkg::DAY_BITS-1:0] i_prev_d,
    input  logic                          i_next_beats,
    input  logic [WB-1:0]                 i_next_w,
    input  logic [UB-1:0]                 i_next_u,
    input  logic [wpjs_pkg::DAY_BITS-1:0] i_next_d,
    output logic                          o_beats,
    output logic [WB-1:0]                 o_w,
    output logic [UB-1:0]                 o_u,
    output logic [wpjs_pkg::DAY_BITS-1:0] o_d
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [WB-1:0]                 r_w, n_w;
    logic [UB-1:0]                 r_u, n_u;
    logic [wpjs_pkg::DAY_BITS-1:0] r_d, n_d;
    logic                          w_valid;

    assign w_valid = i_count > IDX_C;

    // priority order: weight, then same day with more units; other ties favor the key
    assign o_beats = w_valid &&
                     ((r_w > i_key_w) ||
                      ((r_w == i_key_w) && (r_d == i_key_d) && (r_u > i_key_u)));

    always_comb begin
        n_w = r_w;
        n_u = r_u;
        n_d = r_d;
        if (i_cmd.rmv) begin
            n_w = i_next_w;
            n_u = i_next_u;
            n_d = i_next_d;
        end else if (i_cmd.srv) begin
            if (i_next_beats) begin
                n_w = i_next_w;
                n_u = i_next_u;
                n_d = i_next_d;
            end else if (o_beats) begin
                n_w = i_key_w;
                n_u = i_key_u;
                n_d = i_key_d;
            end
        end else if (i_cmd.ins) begin
            if (!o_beats) begin
                if (i_prev_beats) begin
                    n_w = i_key_w;
                    n_u = i_key_u;
                    n_d = i_key_d;
                end else begin
                    n_w = i_prev_w;
                    n_u = i_prev_u;
                    n_d = i_prev_d;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_u <= n_u;
        r_d <= n_d;
    end

    assign o_w = r_w;
    assign o_u = r_u;
    assign o_d = r_d;

endmodule

/* src/wpjs_chain.sv */
// ----------------------------------------------------------------------------
// wpjs_chain
// Row of job cells kept sorted by priority; the head cell is the next to serve.
// ----------------------------------------------------------------------------
module wpjs_chain #(
    parameter int CAPACITY = 64,
    parameter int WB       = 16,
    parameter int UB       = 16,
    parameter int CW       = 7
) (
    input  logic                          i_clk,
    input  wpjs_pkg::t_chain_cmd          i_cmd,
    input  logic [CW-1:0]                 i_count,
    input  logic [WB-1:0]                 i_key_w,
    input  logic [UB-1:0]                 i_key_u,
    input  logic [wpjs_pkg::DAY_BITS-1:0] i_key_d,
    output logic [WB-1:0]                 o_head_w,
    output logic [UB-1:0]                 o_head_u,
    output logic [wpjs_pkg::DAY_BITS-1:0] o_head_d
);

    logic                          c_beats [CAPACITY];
    logic [WB-1:0]                 c_w     [CAPACITY];
    logic [UB-1:0]                 c_u     [CAPACITY];
    logic [wpjs_pkg::DAY_BITS-1:0] c_d     [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                          w_prev_beats, w_next_beats;
        logic [WB-1:0]                 w_prev_w, w_next_w;
        logic [UB-1:0]                 w_prev_u, w_next_u;
        logic [wpjs_pkg::DAY_BITS-1:0] w_prev_d, w_next_d;

        if (g == 0) begin : g_first
            assign w_prev_beats = 1'b1;
            assign w_prev_w     = '0;
            assign w_prev_u     = '0;
            assign w_prev_d     = '0;
        end else begin : g_mid_prev
            assign w_prev_beats = c_beats[g-1];
            assign w_prev_w     = c_w[g-1];
            assign w_prev_u     = c_u[g-1];
            assign w_prev_d     = c_d[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next_beats = 1'b0;
            assign w_next_w     = '0;
            assign w_next_u     = '0;
            assign w_next_d     = '0;
        end else begin : g_mid_next
            assign w_next_beats = c_beats[g+1];
            assign w_next_w     = c_w[g+1];
            assign w_next_u     = c_u[g+1];
            assign w_next_d     = c_d[g+1];
        end

        wpjs_cell #(
            .IDX (g),
            .WB  (WB),
            .UB  (UB),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (i_cmd),
            .i_count      (i_count),
            .i_key_w      (i_key_w),
            .i_key_u      (i_key_u),
            .i_key_d      (i_key_d),
            .i_prev_beats (w_prev_beats),
            .i_prev_w     (w_prev_w),
            .i_prev_u     (w_prev_u),
            .i_prev_d     (w_prev_d),
            .i_next_beats (w_next_beats),
            .i_next_w     (w_next_w),
            .i_next_u     (w_next_u),
            .i_next_d     (w_next_d),
            .o_beats      (c_beats[g]),
            .o_w          (c_w[g]),
            .o_u          (c_u[g]),
            .o_d          (c_d[g])
        );
    end

    assign o_head_w = c_w[0];
    assign o_head_u = c_u[0];
    assign o_head_d = c_d[0];

endmodule
